// ===== hw/rtl/gad_pkg.sv =====
// Shared types, constants and ROM tables for the gated distortion core.
`default_nettype none

package gad_pkg;

  // Table sizes (points = entries + 1)
  localparam int EXP_ENTRIES  = 256;
  localparam int TANH_ENTRIES = 256;
  localparam int EXP_IW       = $clog2(EXP_ENTRIES + 1);
  localparam int TANH_IW      = $clog2(TANH_ENTRIES + 1);

  // Position word widths: exp position is t * entries, tanh position is h * entries
  localparam int EXP_POS_W    = 30 + EXP_IW;
  localparam int EXP_IDX_W    = EXP_POS_W - 27;
  localparam int TANH_POS_W   = 27 + TANH_IW;
  localparam int TANH_IDX_W   = TANH_POS_W - 26;

  // Pipeline depth: lane stages plus the output register
  localparam int LANE_STAGES  = 9;
  localparam int PIPE_STAGES  = LANE_STAGES + 1;

  // Sample and register widths
  localparam int SAMPLE_W     = 24;
  localparam int THR_W        = 19;
  localparam int DRIVE_W      = 17;
  localparam int GAIN_W       = 22;
  localparam int PRE_W        = 21;
  localparam int POST_W       = 17;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 22;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GATE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_GAIN     = 2'd2;

  // Register reset values
  localparam logic [THR_W-1:0]   GATE_THRESHOLD_RST = 19'd41943;
  localparam logic [DRIVE_W-1:0] DRIVE_RST          = 17'd32768;
  localparam logic [GAIN_W-1:0]  LEVEL_GAIN_RST     = 22'd65536;

  // Full scale in Q1.23
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 24'h800000;
  localparam logic [SAMPLE_W-1:0] MAX_POS    = 24'h7FFFFF;

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef logic [SAMPLE_W-1:0] exp_rom_t  [0:EXP_ENTRIES];
  typedef logic [SAMPLE_W-1:0] tanh_rom_t [0:TANH_ENTRIES];

  // Settings derived from the registers, as the lanes see them
  typedef struct packed {
    logic [THR_W-1:0]  gate_threshold;
    logic [PRE_W-1:0]  pre_gain;
    logic [POST_W-1:0] post_gain;
    logic [GAIN_W-1:0] level_gain;
  } gad_cfg_t;

  // Input scale 1 + 12*drive in Q.16
  function automatic logic [PRE_W-1:0] pre_of(input logic [DRIVE_W-1:0] d);
    return PRE_W'(21'd65536 + PRE_W'(d) * 21'd12);
  endfunction

  // Shaper output scale 0.3 + 0.7*drive in Q.16
  function automatic logic [POST_W-1:0] post_of(input logic [DRIVE_W-1:0] d);
    logic [33:0] p;
    p = 34'(d) * 34'd45875;
    return POST_W'(17'd19661 + p[32:16]);
  endfunction

  // Shift-and-subtract quotient of two 64-bit words, used while the tables are built
  function automatic logic [63:0] div_q64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= 65'(den)) begin
        r    = r - 65'(den);
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-t) in Q30 for t in Q30: series on t/32, then square five times
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] t);
    logic [63:0] v;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] den;
    v    = (t + 64'd16) >> 5;
    sum  = ONE_Q30;
    term = ONE_Q30;
    for (int n = 1; n <= 24; n++) begin
      if (term != 64'd0) begin
        den  = 64'(n) << 30;
        term = div_q64(term * v, den);
        if ((n % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    for (int i = 0; i < 5; i++) begin
      sum = (sum * sum + (ONE_Q30 >> 1)) >> 30;
    end
    return sum;
  endfunction

  // exp(-t) points over t = 0..16, Q.23 rounded
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] e;
    for (int k = 0; k <= EXP_ENTRIES; k++) begin
      e      = exp_neg_q30((64'(k) << 34) / EXP_ENTRIES);
      rom[k] = SAMPLE_W'((e + 64'd64) >> 7);
    end
    return rom;
  endfunction

  // tanh(h) points over h = 0..8, Q.23 rounded
  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t   rom;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    for (int k = 0; k <= TANH_ENTRIES; k++) begin
      e      = exp_neg_q30((64'(k) << 34) / TANH_ENTRIES);
      num    = (ONE_Q30 - e) << 23;
      den    = ONE_Q30 + e;
      rom[k] = SAMPLE_W'(div_q64(num + (den >> 1), den));
    end
    return rom;
  endfunction

  localparam exp_rom_t  EXP_ROM  = build_exp_rom();
  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

`default_nettype wire

// ===== hw/rtl/gad_cfg.sv =====
// Configuration register file with derived drive gains.
`default_nettype none

module gad_cfg
  import gad_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output gad_cfg_t                   cfg
);

  // Always take a write
  assign cfg_ready = 1'b1;

  // Store registers; drive is kept as its two derived gains
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gate_threshold <= GATE_THRESHOLD_RST;
      cfg.pre_gain       <= pre_of(DRIVE_RST);
      cfg.post_gain      <= post_of(DRIVE_RST);
      cfg.level_gain     <= LEVEL_GAIN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GATE_THRESHOLD: cfg.gate_threshold <= cfg_data[THR_W-1:0];
        REG_DRIVE: begin
          cfg.pre_gain  <= pre_of(cfg_data[DRIVE_W-1:0]);
          cfg.post_gain <= post_of(cfg_data[DRIVE_W-1:0]);
        end
        REG_LEVEL_GAIN: cfg.level_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gad_lane.sv =====
// One channel lane: gate, exp clip, tanh and level gain, nine register stages.
`default_nettype none

module gad_lane
  import gad_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic [LANE_STAGES-1:0]     en,
  input  wire gad_cfg_t                   cfg,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  output logic signed [SAMPLE_W-1:0]      result
);

  // Sign and gate flags travel with the sample
  logic [LANE_STAGES-1:0] neg_pipe;
  logic [LANE_STAGES-1:0] kill_pipe;

  // Stage 0: magnitude, gate, input gain
  logic                neg0;
  logic [SAMPLE_W-1:0] mag0;
  logic                kill0;
  logic [44:0]         s0_prod;

  assign neg0  = sample[SAMPLE_W-1];
  assign mag0  = neg0 ? (~sample + 24'd1) : sample;
  assign kill0 = (mag0 < SAMPLE_W'(cfg.gate_threshold));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_prod <= 45'(mag0) * 45'(cfg.pre_gain);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg_pipe[0]  <= neg0;
      kill_pipe[0] <= kill0;
    end
    for (int i = 1; i < LANE_STAGES; i++) begin
      if (en[i]) begin
        neg_pipe[i]  <= neg_pipe[i-1];
        kill_pipe[i] <= kill_pipe[i-1];
      end
    end
  end

  // Stage 1: t = 1.5*m, exp table position
  logic [28:0]          m1;
  logic [30:0]          t3;
  logic [29:0]          t1;
  logic [EXP_POS_W-1:0] s1_pos;

  assign m1 = s0_prod[44:16];
  assign t3 = {2'b00, m1} + {1'b0, m1, 1'b0};
  assign t1 = t3[30:1];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_pos <= EXP_POS_W'(t1) * EXP_POS_W'(EXP_ENTRIES);
    end
  end

  // Stage 2: exp table read, difference of neighbors
  logic [EXP_IDX_W-1:0] eidx_full;
  logic                 eover;
  logic [EXP_IW-1:0]    eidx;
  logic [SAMPLE_W-1:0]  ea;
  logic [SAMPLE_W-1:0]  eb;
  logic [SAMPLE_W-1:0]  s2_a;
  logic [SAMPLE_W-1:0]  s2_dmag;
  logic                 s2_up;
  logic                 s2_over;
  logic [26:0]          s2_frac;

  assign eidx_full = s1_pos[EXP_POS_W-1:27];
  assign eover     = (eidx_full >= EXP_IDX_W'(EXP_ENTRIES));
  assign eidx      = eover ? '0 : eidx_full[EXP_IW-1:0];
  assign ea        = EXP_ROM[eidx];
  assign eb        = EXP_ROM[eidx + EXP_IW'(1)];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_a    <= ea;
      s2_up   <= (eb >= ea);
      s2_dmag <= (eb >= ea) ? (eb - ea) : (ea - eb);
      s2_over <= eover;
      s2_frac <= s1_pos[26:0];
    end
  end

  // Stage 3: exp interpolation product
  logic [50:0]         eprod;
  logic [SAMPLE_W-1:0] s3_a;
  logic [SAMPLE_W-1:0] s3_dp;
  logic                s3_up;
  logic                s3_over;

  assign eprod = 51'(s2_dmag) * 51'(s2_frac);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_a    <= s2_a;
      s3_dp   <= eprod[50:27];
      s3_up   <= s2_up;
      s3_over <= s2_over;
    end
  end

  // Stage 4: clip c = 1 - e, output drive gain
  logic [SAMPLE_W-1:0] e4;
  logic [SAMPLE_W-1:0] c4;
  logic [40:0]         s4_prod;

  assign e4 = s3_over ? '0 : (s3_up ? (s3_a + s3_dp) : (s3_a - s3_dp));
  assign c4 = (e4 >= FULL_SCALE) ? '0 : (FULL_SCALE - e4);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_prod <= 41'(c4) * 41'(cfg.post_gain);
    end
  end

  // Stage 5: tanh table position
  logic [24:0]           h5;
  logic [TANH_POS_W-1:0] s5_pos;

  assign h5 = s4_prod[40:16];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_pos <= TANH_POS_W'(h5) * TANH_POS_W'(TANH_ENTRIES);
    end
  end

  // Stage 6: tanh table read; hold the last point past the end
  logic [TANH_IDX_W-1:0] tidx_full;
  logic                  tover;
  logic [TANH_IW-1:0]    tidx;
  logic [SAMPLE_W-1:0]   ta;
  logic [SAMPLE_W-1:0]   tb;
  logic [SAMPLE_W-1:0]   s6_a;
  logic [SAMPLE_W-1:0]   s6_dmag;
  logic                  s6_up;
  logic [25:0]           s6_frac;

  assign tidx_full = s5_pos[TANH_POS_W-1:26];
  assign tover     = (tidx_full >= TANH_IDX_W'(TANH_ENTRIES));
  assign tidx      = tover ? '0 : tidx_full[TANH_IW-1:0];
  assign ta        = TANH_ROM[tidx];
  assign tb        = TANH_ROM[tidx + TANH_IW'(1)];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      if (tover) begin
        s6_a    <= TANH_ROM[TANH_ENTRIES];
        s6_up   <= 1'b1;
        s6_dmag <= '0;
      end else begin
        s6_a    <= ta;
        s6_up   <= (tb >= ta);
        s6_dmag <= (tb >= ta) ? (tb - ta) : (ta - tb);
      end
      s6_frac <= s5_pos[25:0];
    end
  end

  // Stage 7: tanh interpolation product
  logic [49:0]         tprod;
  logic [SAMPLE_W-1:0] s7_a;
  logic [SAMPLE_W-1:0] s7_dp;
  logic                s7_up;

  assign tprod = 50'(s6_dmag) * 50'(s6_frac);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_a  <= s6_a;
      s7_dp <= tprod[49:26];
      s7_up <= s6_up;
    end
  end

  // Stage 8: level gain
  logic [SAMPLE_W-1:0] th8;
  logic [45:0]         s8_prod;

  assign th8 = s7_up ? (s7_a + s7_dp) : (s7_a - s7_dp);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_prod <= 46'(th8) * 46'(cfg.level_gain);
    end
  end

  // Saturate, restore sign, apply gate
  logic [29:0]         y;
  logic [SAMPLE_W-1:0] ymag;

  assign y = s8_prod[45:16];

  always_comb begin
    ymag = '0;
    if (kill_pipe[LANE_STAGES-1]) begin
      result = '0;
    end else if (neg_pipe[LANE_STAGES-1]) begin
      ymag   = (y > 30'(FULL_SCALE)) ? FULL_SCALE : y[SAMPLE_W-1:0];
      result = ~ymag + 24'd1;
    end else begin
      result = (y > 30'(MAX_POS)) ? MAX_POS : y[SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gated_asymmetric_distortion_core.sv =====
// Top level: config registers, two channel lanes and the merged output register.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid / in_ready     left_in, right_in (Q1.23)
//   out      source     out_valid / out_ready   left_out, right_out (Q1.23)
//   cfg      sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One stereo pair per cycle while out_ready does not hold the pipe; a pair passes nine lane stages (five
// multiplies, two table positions and two table reads, each registered)
// plus the output register.
// Reset clears all stage valid bits and loads the register reset values.
// A stage holds while its successor is full and blocked; empty stages fill,
// so input is taken while a result waits. cfg_ready is always high.
`default_nettype none

module gated_asymmetric_distortion_core
  import gad_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] left_in,
  input  wire logic signed [SAMPLE_W-1:0] right_in,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_W-1:0]      left_out,
  output logic signed [SAMPLE_W-1:0]      right_out,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data
);

  gad_cfg_t               cfg;
  logic [PIPE_STAGES-1:0] valid;
  logic [PIPE_STAGES-1:0] en;
  logic signed [SAMPLE_W-1:0] left_res;
  logic signed [SAMPLE_W-1:0] right_res;

  gad_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[PIPE_STAGES-1] = !valid[PIPE_STAGES-1] || out_ready;
    for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = valid[PIPE_STAGES-1];

  // Track which stages hold a request
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  gad_lane u_lane_left (
    .clk    (clk),
    .en     (en[LANE_STAGES-1:0]),
    .cfg    (cfg),
    .sample (left_in),
    .result (left_res)
  );

  gad_lane u_lane_right (
    .clk    (clk),
    .en     (en[LANE_STAGES-1:0]),
    .cfg    (cfg),
    .sample (right_in),
    .result (right_res)
  );

  // Merge both lanes into the output register
  always_ff @(posedge clk) begin
    if (en[PIPE_STAGES-1]) begin
      left_out  <= left_res;
      right_out <= right_res;
    end
  end

endmodule

`default_nettype wire

// ===== tb/gated_asymmetric_distortion_core_test.sv =====
// Self-checking regression for the gated asymmetric distortion core.
`timescale 1ns / 100ps

module gated_asymmetric_distortion_core_test;
  import gad_pkg::*;

  localparam int CURVE_PTS     = 256;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 14;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_OFF_LEN  = 300;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
  localparam logic [63:0] FULL_Q23 = 64'd1 << 23;

  localparam int unsigned THR_MAX  = 419430;
  localparam int unsigned DRIVE_MAX = 65536;
  localparam int unsigned GAIN_MIN = 65536;
  localparam int unsigned GAIN_MAX = 2609152;

  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left_s;
    logic [SAMPLE_W-1:0] right_s;
  } stereo_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] left_in = '0;
  logic signed [SAMPLE_W-1:0] right_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  // Shaper settings as the hardware should hold them
  logic [THR_W-1:0]   thr_q   = GATE_THRESHOLD_RST;
  logic [DRIVE_W-1:0] drive_q = DRIVE_RST;
  logic [GAIN_W-1:0]  gain_q  = LEVEL_GAIN_RST;

  logic [63:0] exp_pts  [0:CURVE_PTS];
  logic [63:0] tanh_pts [0:CURVE_PTS];

  stereo_t pending_pairs[$];
  int      fault_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_req = 0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  gated_asymmetric_distortion_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .left_in   (left_in),
    .right_in  (right_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_out  (left_out),
    .right_out (right_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // exp(-t), Q30 in and out: alternating series on t/32, then square five times
  function automatic logic [63:0] decay_q30(input logic [63:0] t);
    logic [63:0] v;
    logic [63:0] acc;
    logic [63:0] term;
    int          n;
    v    = (t + 64'd16) >> 5;
    acc  = Q30_ONE;
    term = Q30_ONE;
    n    = 1;
    while (n <= 24 && term != 64'd0) begin
      term = (term * v) / (64'(n) << 30);
      if (n[0]) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
      n++;
    end
    repeat (5) acc = (acc * acc + (Q30_ONE >> 1)) >> 30;
    return acc;
  endfunction

  // Fill both curve tables: exp over 0..16, tanh over 0..8, Q.23 rounded
  task automatic build_curves();
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    for (int k = 0; k <= CURVE_PTS; k++) begin
      e          = decay_q30((64'(k) << 34) / CURVE_PTS);
      exp_pts[k] = (e + 64'd64) >> 7;
      num        = (Q30_ONE - e) << 23;
      den        = Q30_ONE + e;
      tanh_pts[k] = (num + (den >> 1)) / den;
    end
  endtask

  function automatic logic [63:0] lerp(input logic [63:0] a, input logic [63:0] b,
                                       input logic [63:0] frac, input int sh);
    if (b >= a) return a + (((b - a) * frac) >> sh);
    return a - (((a - b) * frac) >> sh);
  endfunction

  // Expected output of one channel under the current settings
  function automatic logic [SAMPLE_W-1:0] shape_sample(input logic [SAMPLE_W-1:0] raw);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] pre;
    logic [63:0] m;
    logic [63:0] t;
    logic [63:0] pos;
    logic [63:0] idx;
    logic [63:0] e;
    logic [63:0] c;
    logic [63:0] post;
    logic [63:0] h;
    logic [63:0] th;
    logic [63:0] y;
    neg = raw[SAMPLE_W-1];
    mag = neg ? (64'h100_0000 - 64'(raw)) : 64'(raw);
    if (mag < 64'(thr_q)) return '0;
    pre = 64'd65536 + 64'd12 * 64'(drive_q);
    m   = (mag * pre) >> 16;
    t   = (64'd3 * m) >> 1;
    // exponential bend
    pos = t * CURVE_PTS;
    idx = pos >> 27;
    if (idx >= CURVE_PTS) begin
      e = '0;
    end else begin
      e = lerp(exp_pts[idx], exp_pts[idx + 1], pos & ((64'd1 << 27) - 1), 27);
    end
    c    = (e >= FULL_Q23) ? 64'd0 : FULL_Q23 - e;
    post = 64'd19661 + ((64'd45875 * 64'(drive_q)) >> 16);
    h    = (c * post) >> 16;
    // tanh soft clip, last point held past the table
    pos = h * CURVE_PTS;
    idx = pos >> 26;
    if (idx >= CURVE_PTS) begin
      th = tanh_pts[CURVE_PTS];
    end else begin
      th = lerp(tanh_pts[idx], tanh_pts[idx + 1], pos & ((64'd1 << 26) - 1), 26);
    end
    y = (th * 64'(gain_q)) >> 16;
    if (neg) begin
      if (y > FULL_Q23) y = FULL_Q23;
      return SAMPLE_W'(64'h100_0000 - y);
    end
    if (y > FULL_Q23 - 1) y = FULL_Q23 - 1;
    return SAMPLE_W'(y);
  endfunction

  task automatic log_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  // Send one request, then queue its expected pair
  task automatic send_pair(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
    stereo_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    left_in  <= l;
    right_in <= r;
    do @(posedge clk); while (!in_ready);
    want.left_s  = shape_sample(l);
    want.right_s = shape_sample(r);
    pending_pairs.push_back(want);
  endtask

  // Drop input valid, wait for every expected pair, then let the pipe empty
  task automatic go_idle();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; valid stays high for the caller to lower
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GATE_THRESHOLD: thr_q   = data[THR_W-1:0];
      REG_DRIVE:          drive_q = data[DRIVE_W-1:0];
      REG_LEVEL_GAIN:     gain_q  = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] thr,
                                input logic [CFG_DATA_W-1:0] drv,
                                input logic [CFG_DATA_W-1:0] gain);
    go_idle();
    write_reg(REG_GATE_THRESHOLD, thr);
    write_reg(REG_DRIVE, drv);
    write_reg(REG_LEVEL_GAIN, gain);
    cfg_valid <= 1'b0;
  endtask

  // Random register value: range ends, reset value, raw 22-bit word or in range
  function automatic logic [CFG_DATA_W-1:0] pick_reg(input logic [CFG_IDX_W-1:0] idx);
    int unsigned lo;
    int unsigned hi;
    int unsigned rv;
    case (idx)
      REG_GATE_THRESHOLD: begin
        lo = 0;
        hi = THR_MAX;
        rv = GATE_THRESHOLD_RST;
      end
      REG_DRIVE: begin
        lo = 0;
        hi = DRIVE_MAX;
        rv = DRIVE_RST;
      end
      default: begin
        lo = GAIN_MIN;
        hi = GAIN_MAX;
        rv = LEVEL_GAIN_RST;
      end
    endcase
    case ($urandom_range(0, 7))
      0:       return CFG_DATA_W'(lo);
      1:       return CFG_DATA_W'(hi);
      2:       return CFG_DATA_W'(rv);
      3:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(lo, hi));
    endcase
  endfunction

  // Random sample, biased toward the gate edge, small and large magnitudes
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int mag;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SAMPLE_W'($urandom);
      4, 5: begin
        mag = int'(thr_q) + int'($urandom_range(0, 8)) - 4;
        if (mag < 0) mag = 0;
      end
      6: mag = int'($urandom_range(0, 65535));
      7: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return MAX_POS;
          2:       return FULL_SCALE;
          default: return '1;
        endcase
      end
      default: mag = int'($urandom_range(1 << 22, 1 << 23));
    endcase
    return $urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
  endfunction

  // Reset values: zero, unit steps, both sides of the gate, full scale
  task automatic test_gate_at_reset_values();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_pair(24'd0, 24'd0);
    send_pair(24'd1, -24'sd1);
    send_pair(24'd41942, -24'sd41942);
    send_pair(24'd41943, -24'sd41943);
    send_pair(MAX_POS, FULL_SCALE);
    send_pair(FULL_SCALE, MAX_POS);
    send_pair(-24'sd41943, 24'd41944);
  endtask

  // Range ends of every register
  task automatic test_setting_extremes();
    apply_settings(0, 0, GAIN_MIN);
    send_pair(24'd0, 24'd0);
    send_pair(24'd1, -24'sd1);
    send_pair(MAX_POS, FULL_SCALE);
    send_pair(24'd123456, -24'sd123456);
    apply_settings(THR_MAX, DRIVE_MAX, GAIN_MAX);
    send_pair(24'd419429, -24'sd419429);
    send_pair(24'd419430, -24'sd419430);
    send_pair(MAX_POS, FULL_SCALE);
    send_pair(24'h400000, -24'sh400000);
  endtask

  // All-ones writes are masked per register; the spare index changes nothing
  task automatic test_unmasked_writes();
    go_idle();
    write_reg(REG_GATE_THRESHOLD, '1);
    write_reg(REG_DRIVE, '1);
    write_reg(REG_LEVEL_GAIN, '1);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    send_pair(24'd524286, -24'sd524287);
    send_pair(MAX_POS, FULL_SCALE);
    send_pair(24'd0, 24'd524287);
    apply_settings(0, DRIVE_MAX, 0);
    send_pair(MAX_POS, FULL_SCALE);
    send_pair(24'd1, -24'sd1);
  endtask

  task automatic test_random_stream(input int idle_in, input int stall_out, input int count);
    for (int blk = 0; blk < 3; blk++) begin
      apply_settings(pick_reg(REG_GATE_THRESHOLD), pick_reg(REG_DRIVE),
                     pick_reg(REG_LEVEL_GAIN));
      send_idle_pct  = idle_in;
      recv_stall_pct = stall_out;
      repeat (count / 3) send_pair(rand_sample(), rand_sample());
    end
  endtask

  // Hold the output off long enough for the pipe to fill and stall the input
  task automatic test_output_hold_off();
    apply_settings(pick_reg(REG_GATE_THRESHOLD), pick_reg(REG_DRIVE),
                   pick_reg(REG_LEVEL_GAIN));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = HOLD_OFF_LEN;
    repeat (100) send_pair(rand_sample(), rand_sample());
  endtask

  initial begin
    build_curves();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_gate_at_reset_values();
    test_setting_extremes();
    test_unmasked_writes();
    test_random_stream(0, 0, 270);
    test_random_stream(50, 0, 270);
    test_random_stream(0, 50, 270);
    test_random_stream(33, 33, 270);
    test_output_hold_off();
    go_idle();
    if (fault_count == 0) begin
      $display("gated_asymmetric_distortion_core regression: pass");
    end else begin
      $display("gated_asymmetric_distortion_core regression: fail");
    end
    $finish;
  end

  // Drive output ready: long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expected pair
  always @(posedge clk) begin
    stereo_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pairs.size() == 0) begin
        log_fault($sformatf("unexpected result left=%0d right=%0d", left_out, right_out));
      end else begin
        want = pending_pairs.pop_front();
        if (left_out !== want.left_s || right_out !== want.right_s) begin
          log_fault($sformatf("mismatch: expected left=%0d right=%0d, got left=%0d right=%0d",
                              $signed(want.left_s), $signed(want.right_s),
                              left_out, right_out));
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("gated_asymmetric_distortion_core regression: fail");
      $finish;
    end
  end

endmodule
